>>> rtl/arcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arcm_pkg
// Shared types, constants and helpers for the AC RMS current meter.
// ----------------------------------------------------------------------------
package arcm_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int COUNT_BITS     = 13;
  localparam int Q8_BITS        = 20;
  localparam int SCALE_BITS     = 32;
  localparam int HALF_BITS      = SCALE_BITS / 2;
  localparam int PROD_BITS      = Q8_BITS + HALF_BITS;
  localparam int BIAS_SUM_BITS  = 24;
  localparam int SQ_BITS        = 2 * Q8_BITS;
  localparam int SQ_SUM_BITS    = 56;
  localparam int DIV_NUM_BITS   = 56;
  localparam int DIV_CNT_BITS   = 6;
  localparam int ROOT_BITS      = 21;
  localparam int RAD_BITS       = 2 * ROOT_BITS;
  localparam int ROOT_REM_BITS  = ROOT_BITS + 2;
  localparam int ROOT_CNT_BITS  = 5;
  localparam int ROOT_STEPS     = ROOT_BITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [COUNT_BITS-1:0] MAX_SAMPLES         = 13'd4096;
  localparam logic [COUNT_BITS-1:0] OFFSET_SAMPLES_INIT = 13'd200;
  localparam logic [COUNT_BITS-1:0] RMS_SAMPLES_INIT    = 13'd1000;
  localparam logic [SCALE_BITS-1:0] AMPS_SCALE_INIT     = 32'd0;

  localparam logic [Q8_BITS-1:0] FIELD_MAX = 20'hFFFFF;
  // largest sample value in Q12.8
  localparam logic [Q8_BITS-1:0] Q8_LIMIT  = 20'hFFF00;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_SAMPLES = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RMS_SAMPLES    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPS_SCALE     = 2'd2;

  typedef struct packed {
    logic [COUNT_BITS-1:0] offset_samples;
    logic [COUNT_BITS-1:0] rms_samples;
    logic [SCALE_BITS-1:0] amps_scale;
  } arcm_cfg_t;

  // sample tagged by the front end with its phase and end-of-phase mark
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   rms_phase;
    logic                   last;
  } arcm_item_t;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_SQUARE,
    ST_BIAS_DIV,
    ST_BIAS_WAIT,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_ROOT,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_EMIT
  } arcm_state_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    r = v;
    if (v == {COUNT_BITS{1'b0}}) begin
      r = COUNT_BITS'(1);
    end else if (v > MAX_SAMPLES) begin
      r = MAX_SAMPLES;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ac_rms_current_meter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ac_rms_current_meter_core
// RMS current meter with DC bias removal over two-phase measurement cycles.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  samples  | push / full      | sample
//  results  | empty / pop      | current_milliamps, rms_counts_q8, offset_q8
//  config   | cfg_we           | cfg_index, cfg_data
//
//  Samples land in a 4-beat queue; the back end pops an offset sample
//  in its fetch state and squares each RMS sample in a separate state.
//  End of offset phase adds a divide (56-step bit-serial divider).
//  End of RMS phase adds the divider, a 21-step square root,
//  two 20x16 multiplies and the result write.
//  A waiting result stalls the back end only when the next result is ready.
//  Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module ac_rms_current_meter_core import arcm_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [SAMPLE_BITS-1:0]    sample,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [Q8_BITS-1:0]             current_milliamps,
  output logic [Q8_BITS-1:0]             rms_counts_q8,
  output logic [Q8_BITS-1:0]             offset_q8,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [SCALE_BITS-1:0]     cfg_data
);

  arcm_cfg_t  cfg;
  logic       queue_full;
  logic       queue_push;
  arcm_item_t queue_in;
  logic       queue_pop;
  arcm_item_t queue_out;
  logic       queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_samples <= OFFSET_SAMPLES_INIT;
      cfg.rms_samples    <= RMS_SAMPLES_INIT;
      cfg.amps_scale     <= AMPS_SCALE_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_SAMPLES: cfg.offset_samples <= cfg_data[COUNT_BITS-1:0];
        REG_RMS_SAMPLES:    cfg.rms_samples    <= cfg_data[COUNT_BITS-1:0];
        REG_AMPS_SCALE:     cfg.amps_scale     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  arcm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .sample     (sample),
    .full       (full),
    .queue_full (queue_full),
    .queue_push (queue_push),
    .queue_item (queue_in)
  );

  arcm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (queue_push),
    .wr_item (queue_in),
    .full    (queue_full),
    .rd_en   (queue_pop),
    .rd_item (queue_out),
    .empty   (queue_empty)
  );

  arcm_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .item_valid        (!queue_empty),
    .item              (queue_out),
    .item_pop          (queue_pop),
    .empty             (empty),
    .pop               (pop),
    .current_milliamps (current_milliamps),
    .rms_counts_q8     (rms_counts_q8),
    .offset_q8         (offset_q8)
  );

endmodule
`default_nettype wire

>>> rtl/arcm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arcm_front
// Accepts samples, tracks phase and sample count, tags each beat.
// ----------------------------------------------------------------------------
module arcm_front import arcm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire arcm_cfg_t              cfg,
  input  wire logic                   push,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        full,
  input  wire logic                   queue_full,
  output logic                        queue_push,
  output arcm_item_t                  queue_item
);

  logic                  phase;
  logic [COUNT_BITS-1:0] counter;
  logic [COUNT_BITS-1:0] count_target;
  logic [COUNT_BITS-1:0] counter_inc;
  logic                  last;

  assign full         = queue_full;
  assign queue_push   = push && !queue_full;
  assign count_target = phase ? eff_count(cfg.rms_samples) : eff_count(cfg.offset_samples);
  assign counter_inc  = counter + COUNT_BITS'(1);
  // >= so that a count lowered mid-phase still closes the phase
  assign last         = (counter_inc >= count_target);

  assign queue_item.sample    = sample;
  assign queue_item.rms_phase = phase;
  assign queue_item.last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= 1'b0;
      counter <= {COUNT_BITS{1'b0}};
    end else if (queue_push) begin
      if (last) begin
        phase   <= !phase;
        counter <= {COUNT_BITS{1'b0}};
      end else begin
        counter <= counter_inc;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/arcm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arcm_fifo
// Short queue of tagged samples between front end and back end.
// ----------------------------------------------------------------------------
module arcm_fifo import arcm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire arcm_item_t wr_item,
  output logic            full,
  input  wire logic       rd_en,
  output arcm_item_t      rd_item,
  output logic            empty
);

  arcm_item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;
  logic                      do_wr;
  logic                      do_rd;

  assign full    = (fill == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (fill == {(QUEUE_PTR_BITS+1){1'b0}});
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= {QUEUE_PTR_BITS{1'b0}};
      rd_ptr <= {QUEUE_PTR_BITS{1'b0}};
      fill   <= {(QUEUE_PTR_BITS+1){1'b0}};
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + (QUEUE_PTR_BITS+1)'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - (QUEUE_PTR_BITS+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/arcm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arcm_div
// Restoring divider, one quotient bit per cycle, shared by bias and mean.
// ----------------------------------------------------------------------------
module arcm_div import arcm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [DIV_NUM_BITS-1:0] num,
  input  wire logic [COUNT_BITS-1:0]   den,
  output logic                         done,
  output logic [DIV_NUM_BITS-1:0]      quo,
  output logic [COUNT_BITS-1:0]        rem
);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] step;
  logic [COUNT_BITS-1:0]   den_r;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     trial_sub;
  logic                    ge;

  assign trial     = {rem, quo[DIV_NUM_BITS-1]};
  assign ge        = (trial >= {1'b0, den_r});
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == DIV_CNT_BITS'(DIV_NUM_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= {COUNT_BITS{1'b0}};
      den_r <= den;
      step  <= {DIV_CNT_BITS{1'b0}};
    end else if (busy) begin
      // partial remainder stays below the divisor, so it fits the count width
      rem  <= ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo  <= {quo[DIV_NUM_BITS-2:0], ge};
      step <= step + DIV_CNT_BITS'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/arcm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arcm_back
// Bias and square accumulation, mean, square root, scaling, result register.
// ----------------------------------------------------------------------------
module arcm_back import arcm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire arcm_cfg_t   cfg,
  input  wire logic        item_valid,
  input  wire arcm_item_t  item,
  output logic             item_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [Q8_BITS-1:0] current_milliamps,
  output logic [Q8_BITS-1:0] rms_counts_q8,
  output logic [Q8_BITS-1:0] offset_q8
);

  localparam int TOTAL_BITS = PROD_BITS + HALF_BITS + 1;
  localparam int MA_SHIFT   = 24;
  localparam int MA_BITS    = TOTAL_BITS - MA_SHIFT;
  localparam logic [TOTAL_BITS-1:0] MA_ROUND = TOTAL_BITS'(1) << (MA_SHIFT - 1);

  arcm_state_t state, state_next;

  logic [BIAS_SUM_BITS-1:0] bias_sum;
  logic [Q8_BITS-1:0]       bias_value;
  logic [SQ_SUM_BITS-1:0]   square_sum;
  logic [Q8_BITS-1:0]       diff;
  logic                     last_sq;
  logic [RAD_BITS-1:0]      rad;
  logic [ROOT_BITS-1:0]     root;
  logic [ROOT_REM_BITS-1:0] root_rem;
  logic [ROOT_CNT_BITS-1:0] root_cnt;
  logic [Q8_BITS-1:0]       rms_val;
  logic [PROD_BITS-1:0]     prod_lo;
  logic [PROD_BITS-1:0]     prod_hi;
  logic                     out_valid;

  logic [COUNT_BITS-1:0]    n_off;
  logic [COUNT_BITS-1:0]    n_rms;
  logic [Q8_BITS-1:0]       sample_q8;
  logic [Q8_BITS-1:0]       diff_calc;
  logic [SQ_BITS-1:0]       diff_sq;
  logic [DIV_NUM_BITS-1:0]  bias_num;
  logic                     div_start;
  logic [DIV_NUM_BITS-1:0]  div_num;
  logic [COUNT_BITS-1:0]    div_den;
  logic                     div_done;
  logic [DIV_NUM_BITS-1:0]  div_quo;
  logic [COUNT_BITS-1:0]    div_rem;
  logic [Q8_BITS-1:0]       bias_clamped;
  logic                     round_up;
  logic [RAD_BITS-1:0]      mean;
  logic [ROOT_REM_BITS+1:0] root_shift;
  logic [ROOT_REM_BITS+1:0] root_trial;
  logic [ROOT_REM_BITS+1:0] root_diff;
  logic                     root_ge;
  logic [Q8_BITS-1:0]       rms_clamped;
  logic [TOTAL_BITS-1:0]    ma_total;
  logic [MA_BITS-1:0]       ma_raw;
  logic [Q8_BITS-1:0]       ma_sat;
  logic                     out_free;

  assign n_off     = eff_count(cfg.offset_samples);
  assign n_rms     = eff_count(cfg.rms_samples);
  assign sample_q8 = {item.sample, 8'h00};
  assign diff_calc = (sample_q8 >= bias_value) ? (sample_q8 - bias_value)
                                               : (bias_value - sample_q8);
  assign diff_sq   = SQ_BITS'(diff) * SQ_BITS'(diff);
  // rounded half up: (sum * 256 + n/2) / n
  assign bias_num  = DIV_NUM_BITS'({bias_sum, 8'h00}) + DIV_NUM_BITS'(n_off >> 1);
  assign div_num   = (state == ST_BIAS_DIV) ? bias_num : square_sum;
  assign div_den   = (state == ST_BIAS_DIV) ? n_off : n_rms;

  assign bias_clamped = (div_quo > DIV_NUM_BITS'(Q8_LIMIT)) ? Q8_LIMIT
                                                            : div_quo[Q8_BITS-1:0];
  assign round_up = (div_rem >= (n_rms - (n_rms >> 1)));
  // mean of squares never exceeds the largest square, so it fits the radicand
  assign mean     = div_quo[RAD_BITS-1:0] + RAD_BITS'(round_up);

  assign root_shift = {root_rem, rad[RAD_BITS-1 -: 2]};
  assign root_trial = (ROOT_REM_BITS+2)'({root, 2'b01});
  assign root_ge    = (root_shift >= root_trial);
  assign root_diff  = root_shift - root_trial;

  assign rms_clamped = (root > ROOT_BITS'(Q8_LIMIT)) ? Q8_LIMIT : root[Q8_BITS-1:0];

  assign ma_total = TOTAL_BITS'(prod_lo) + TOTAL_BITS'({prod_hi, {HALF_BITS{1'b0}}})
                    + MA_ROUND;
  assign ma_raw   = ma_total[TOTAL_BITS-1:MA_SHIFT];
  assign ma_sat   = (ma_raw > MA_BITS'(FIELD_MAX)) ? FIELD_MAX : ma_raw[Q8_BITS-1:0];

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  arcm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FETCH;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_FETCH: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.rms_phase) begin
            state_next = ST_SQUARE;
          end else if (item.last) begin
            state_next = ST_BIAS_DIV;
          end
        end
      end
      ST_SQUARE: begin
        state_next = last_sq ? ST_MEAN_DIV : ST_FETCH;
      end
      ST_BIAS_DIV: begin
        div_start  = 1'b1;
        state_next = ST_BIAS_WAIT;
      end
      ST_BIAS_WAIT: begin
        if (div_done) begin
          state_next = ST_FETCH;
        end
      end
      ST_MEAN_DIV: begin
        div_start  = 1'b1;
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_cnt == ROOT_CNT_BITS'(ROOT_STEPS - 1)) begin
          state_next = ST_SCALE_LO;
        end
      end
      ST_SCALE_LO: begin
        state_next = ST_SCALE_HI;
      end
      ST_SCALE_HI: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_FETCH;
        end
      end
      default: begin
        state_next = ST_FETCH;
      end
    endcase
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_sum   <= {BIAS_SUM_BITS{1'b0}};
      bias_value <= {Q8_BITS{1'b0}};
      square_sum <= {SQ_SUM_BITS{1'b0}};
    end else begin
      if (state == ST_FETCH && item_valid && !item.rms_phase) begin
        bias_sum <= bias_sum + BIAS_SUM_BITS'(item.sample);
      end
      if (state == ST_SQUARE) begin
        square_sum <= square_sum + SQ_SUM_BITS'(diff_sq);
      end
      if (state == ST_BIAS_WAIT && div_done) begin
        bias_value <= bias_clamped;
        bias_sum   <= {BIAS_SUM_BITS{1'b0}};
      end
      // divider has latched the sum by now
      if (state == ST_MEAN_WAIT && div_done) begin
        square_sum <= {SQ_SUM_BITS{1'b0}};
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_FETCH && item_valid && item.rms_phase) begin
      diff    <= diff_calc;
      last_sq <= item.last;
    end
    if (state == ST_MEAN_WAIT && div_done) begin
      rad      <= mean;
      root     <= {ROOT_BITS{1'b0}};
      root_rem <= {ROOT_REM_BITS{1'b0}};
      root_cnt <= {ROOT_CNT_BITS{1'b0}};
    end
    if (state == ST_ROOT) begin
      rad      <= {rad[RAD_BITS-3:0], 2'b00};
      root     <= {root[ROOT_BITS-2:0], root_ge};
      root_rem <= root_ge ? root_diff[ROOT_REM_BITS-1:0] : root_shift[ROOT_REM_BITS-1:0];
      root_cnt <= root_cnt + ROOT_CNT_BITS'(1);
    end
    if (state == ST_SCALE_LO) begin
      rms_val <= rms_clamped;
      prod_lo <= PROD_BITS'(rms_clamped) * PROD_BITS'(cfg.amps_scale[HALF_BITS-1:0]);
    end
    if (state == ST_SCALE_HI) begin
      prod_hi <= PROD_BITS'(rms_val) * PROD_BITS'(cfg.amps_scale[SCALE_BITS-1:HALF_BITS]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      current_milliamps <= ma_sat;
      rms_counts_q8     <= rms_val;
      offset_q8         <= bias_value;
    end
  end

endmodule
`default_nettype wire
